@@ hdl/ojd_pkg.sv @@
package ojd_pkg;

	localparam int POS_W   = 48;
	localparam int MASS_W  = 32;
	localparam int SQ_W    = 96;
	localparam int ROOT_W  = 48;
	localparam int NUM_W   = 128;
	localparam int DEN_W   = 96;
	localparam int QUO_W   = 61;
	localparam int MQ_W    = 64;
	localparam int MU_W    = 50;
	localparam int J2_W    = 32;
	localparam int RE_W    = 27;
	localparam int RESQ_W  = 54;
	localparam int VE_W    = 32;
	localparam int RATE_W  = 33;
	localparam int CFG_W   = 50;
	localparam int IN_W    = 352;
	localparam int OUT_W   = 328;

	localparam int FRONT_LAT = 4;
	localparam int SQRT_LAT  = ROOT_W;
	localparam int DIV_LAT   = QUO_W;
	localparam int MULQ_LAT  = 2;
	localparam int ACC_LAT   = 5 * MULQ_LAT + 1;
	localparam int TOTAL_LAT = FRONT_LAT + SQRT_LAT + DIV_LAT + ACC_LAT;

	localparam logic [MQ_W-1:0] CAP          = 64'h1000_0000_0000_0000;
	localparam logic [MQ_W-1:0] THREE_HALVES = 64'h0000_0001_8000_0000;
	localparam logic [MQ_W-1:0] ONE_Q32      = 64'h0000_0001_0000_0000;
	localparam logic [MQ_W-1:0] THREE_Q32    = 64'h0000_0003_0000_0000;
	localparam logic [RATE_W-1:0] MR_CAP     = 33'h1_0000_0000;

	localparam logic [MU_W-1:0] MU_RESET = 50'd398600441800000;
	localparam logic [J2_W-1:0] J2_RESET = 32'd4649860;
	localparam logic [RE_W-1:0] RE_RESET = 27'd6378137;
	localparam logic [VE_W-1:0] VE_RESET = 32'd196608000;

	typedef enum logic [1:0] {
		CFG_MU,
		CFG_J2,
		CFG_RE,
		CFG_VE
	} cfg_idx_t;

	typedef struct packed {
		logic [MASS_W-1:0]          thrust;
		logic [MASS_W-1:0]          mass;
		logic [2:0][POS_W-1:0]      vel;
		logic [2:0][POS_W-1:0]      pos;
	} item_t;

	typedef struct packed {
		logic [2:0][POS_W-1:0] pm;
		logic [2:0][POS_W-1:0] vm;
		logic [2:0][POS_W-1:0] vel;
		logic [2:0]            pneg;
		logic [2:0]            vneg;
		logic [MASS_W-1:0]     mass;
		logic [MASS_W-1:0]     thrust;
		logic [SQ_W-1:0]       r2;
		logic [SQ_W-1:0]       v2;
		logic                  fault;
		logic                  moving;
	} front_t;

	typedef struct packed {
		logic [2:0][POS_W-1:0] vel;
		logic [2:0]            pneg;
		logic [2:0]            vneg;
		logic                  fault;
		logic                  moving;
	} mid_t;

	typedef struct packed {
		logic [MQ_W-1:0]       g;
		logic [MQ_W-1:0]       q;
		logic [MQ_W-1:0]       tm;
		logic [2:0][MQ_W-1:0]  u;
		logic [2:0][MQ_W-1:0]  w;
		logic [2:0]            pneg;
		logic [2:0]            vneg;
		logic                  fault;
		logic                  moving;
	} acc_in_t;

	typedef struct packed {
		logic [2:0][POS_W-1:0] vel;
		logic [RATE_W-1:0]     mass_rate;
		logic                  fault;
	} tail_t;

	// Quotient held at the common ceiling once it passes it or overflowed the pipeline.
	function automatic logic [MQ_W-1:0] cap_quo(input logic [QUO_W-1:0] quo, input logic ovf);
		logic [MQ_W-1:0] wide;
		wide = MQ_W'(quo);
		return (ovf || (wide > CAP)) ? CAP : wide;
	endfunction

endpackage

@@ hdl/ojd_front.sv @@
module ojd_front (
	input  logic            clk,
	input  logic            en,
	input  ojd_pkg::item_t  item,
	output ojd_pkg::front_t res
);
	import ojd_pkg::*;

	front_t f_in, f_s1, f_s2, f_s3, f_s4, f_sum;
	logic [2:0][POS_W-1:0] pll_s2, plh_s2, phh_s2, vll_s2, vlh_s2, vhh_s2;
	logic [2:0][SQ_W-1:0]  psq_s3, vsq_s3;

	always_comb begin
		f_in = '0;
		for (int i = 0; i < 3; i++) begin
			f_in.pneg[i] = item.pos[i][POS_W-1];
			f_in.vneg[i] = item.vel[i][POS_W-1];
			f_in.pm[i]   = item.pos[i][POS_W-1] ? (~item.pos[i] + POS_W'(1)) : item.pos[i];
			f_in.vm[i]   = item.vel[i][POS_W-1] ? (~item.vel[i] + POS_W'(1)) : item.vel[i];
		end
		f_in.vel    = item.vel;
		f_in.mass   = item.mass;
		f_in.thrust = item.thrust;
	end

	// The squared lengths and the fault and motion flags join the third stage's fields.
	always_comb begin
		f_sum        = f_s3;
		f_sum.r2     = psq_s3[0] + psq_s3[1] + psq_s3[2];
		f_sum.v2     = vsq_s3[0] + vsq_s3[1] + vsq_s3[2];
		f_sum.fault  = (f_s3.pm == '0) || (f_s3.mass == '0);
		f_sum.moving = (f_s3.vm != '0);
	end

	// Each 48 bit square is built from three 24 by 24 partial products.
	always_ff @(posedge clk) begin
		if (en) begin
			f_s1 <= f_in;
			f_s2 <= f_s1;
			for (int i = 0; i < 3; i++) begin
				pll_s2[i] <= f_s1.pm[i][23:0] * f_s1.pm[i][23:0];
				plh_s2[i] <= f_s1.pm[i][23:0] * f_s1.pm[i][47:24];
				phh_s2[i] <= f_s1.pm[i][47:24] * f_s1.pm[i][47:24];
				vll_s2[i] <= f_s1.vm[i][23:0] * f_s1.vm[i][23:0];
				vlh_s2[i] <= f_s1.vm[i][23:0] * f_s1.vm[i][47:24];
				vhh_s2[i] <= f_s1.vm[i][47:24] * f_s1.vm[i][47:24];
			end
			f_s3 <= f_s2;
			for (int i = 0; i < 3; i++) begin
				psq_s3[i] <= {phh_s2[i], 48'd0} + {23'd0, plh_s2[i], 25'd0} + {48'd0, pll_s2[i]};
				vsq_s3[i] <= {vhh_s2[i], 48'd0} + {23'd0, vlh_s2[i], 25'd0} + {48'd0, vll_s2[i]};
			end
			f_s4 <= f_sum;
		end
	end

	assign res = f_s4;

endmodule

@@ hdl/ojd_isqrt.sv @@
module ojd_isqrt (
	input  logic                       clk,
	input  logic                       en,
	input  logic [ojd_pkg::SQ_W-1:0]   x,
	output logic [ojd_pkg::ROOT_W-1:0] root
);
	import ojd_pkg::*;

	localparam int TW = SQ_W + 1;

	logic [SQ_W-1:0]   rem_q [SQRT_LAT];
	logic [ROOT_W-1:0] res_q [SQRT_LAT];

	// One result bit per stage, most significant first; the remainder holds x minus root squared.
	for (genvar k = 0; k < SQRT_LAT; k++) begin : g_bit
		localparam int B = ROOT_W - 1 - k;
		logic [SQ_W-1:0]   rem_in;
		logic [ROOT_W-1:0] res_in;
		logic [TW-1:0]     trial;

		if (k == 0) begin : g_first
			assign rem_in = x;
			assign res_in = '0;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign res_in = res_q[k-1];
		end

		always_comb trial = ((TW'(res_in) << 1) | (TW'(1) << B)) << B;

		always_ff @(posedge clk) begin
			if (en) begin
				if (trial <= {1'b0, rem_in}) begin
					rem_q[k] <= rem_in - trial[SQ_W-1:0];
					res_q[k] <= res_in | (ROOT_W'(1) << B);
				end else begin
					rem_q[k] <= rem_in;
					res_q[k] <= res_in;
				end
			end
		end
	end

	assign root = res_q[SQRT_LAT-1];

endmodule

@@ hdl/ojd_div.sv @@
module ojd_div (
	input  logic                      clk,
	input  logic                      en,
	input  logic [ojd_pkg::NUM_W-1:0] num,
	input  logic [ojd_pkg::DEN_W-1:0] den,
	output logic [ojd_pkg::QUO_W-1:0] quo,
	output logic                      ovf
);
	import ojd_pkg::*;

	logic [DEN_W-1:0] rem_q [DIV_LAT];
	logic [DEN_W-1:0] den_q [DIV_LAT];
	logic [QUO_W-1:0] low_q [DIV_LAT];
	logic [QUO_W-1:0] quo_q [DIV_LAT];
	logic             ovf_q [DIV_LAT];

	// The quotient only fits when the upper part of the numerator is below the divisor.
	for (genvar k = 0; k < DIV_LAT; k++) begin : g_bit
		logic [DEN_W-1:0] rem_in, den_in;
		logic [QUO_W-1:0] low_in, quo_in;
		logic             ovf_in, ge;
		logic [DEN_W:0]   trial, diff;

		if (k == 0) begin : g_first
			assign rem_in = DEN_W'(num[NUM_W-1:QUO_W]);
			assign den_in = den;
			assign low_in = num[QUO_W-1:0];
			assign quo_in = '0;
			assign ovf_in = (DEN_W'(num[NUM_W-1:QUO_W]) >= den);
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign den_in = den_q[k-1];
			assign low_in = low_q[k-1];
			assign quo_in = quo_q[k-1];
			assign ovf_in = ovf_q[k-1];
		end

		always_comb begin
			trial = {rem_in, low_in[QUO_W-1-k]};
			ge    = (trial >= {1'b0, den_in});
			diff  = trial - {1'b0, den_in};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				quo_q[k] <= {quo_in[QUO_W-2:0], ge};
				den_q[k] <= den_in;
				low_q[k] <= low_in;
				ovf_q[k] <= ovf_in;
			end
		end
	end

	assign quo = quo_q[DIV_LAT-1];
	assign ovf = ovf_q[DIV_LAT-1];

endmodule

@@ hdl/ojd_mulq.sv @@
module ojd_mulq (
	input  logic                     clk,
	input  logic                     en,
	input  logic [ojd_pkg::MQ_W-1:0] a,
	input  logic [ojd_pkg::MQ_W-1:0] b,
	output logic [ojd_pkg::MQ_W-1:0] y
);
	import ojd_pkg::*;

	logic [MQ_W-1:0]   p00_s1, p01_s1, p10_s1, p11_s1;
	logic [2*MQ_W-1:0] full;
	logic [MQ_W-1:0]   y_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1 <= a[31:0]  * b[31:0];
			p01_s1 <= a[31:0]  * b[63:32];
			p10_s1 <= a[63:32] * b[31:0];
			p11_s1 <= a[63:32] * b[63:32];
		end
	end

	always_comb begin
		full = {p11_s1, 64'd0} + {32'd0, p01_s1, 32'd0} + {32'd0, p10_s1, 32'd0}
			+ {64'd0, p00_s1};
	end

	// Product scaled down by two to the 32, held at the ceiling when it grows past it.
	always_ff @(posedge clk) begin
		if (en) begin
			y_s2 <= ((full[127:96] != '0) || (full[95:32] > CAP)) ? CAP : full[95:32];
		end
	end

	assign y = y_s2;

endmodule

@@ hdl/ojd_accel.sv @@
module ojd_accel (
	input  logic                            clk,
	input  logic                            en,
	input  logic [ojd_pkg::J2_W-1:0]        j2,
	input  ojd_pkg::acc_in_t                din,
	output logic [2:0][ojd_pkg::POS_W-1:0]  acc
);
	import ojd_pkg::*;

	typedef struct packed {
		logic [2:0][MQ_W-1:0] fm;
		logic [2:0]           fneg;
	} fm_t;

	typedef struct packed {
		logic [2:0][MQ_W-1:0] c;
		logic [2:0][MQ_W-1:0] t;
	} ct_t;

	localparam int SIDE_N = ACC_LAT - 1;
	localparam int LATE_N = ACC_LAT - 1 - MULQ_LAT;
	localparam logic signed [MQ_W-1:0] ACC_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [MQ_W-1:0] ACC_MIN = 64'shFFFF_8000_0000_0000;

	acc_in_t side_q [SIDE_N];
	fm_t     fm_q   [LATE_N];
	ct_t     ct_q   [LATE_N];
	fm_t     fm_new;

	logic [MQ_W-1:0]      a_l1, dz_l1, k1_l2, k_l3, d;
	logic [2:0][MQ_W-1:0] c_l1, t_l1, jj_l4, j_l5;
	logic [2:0][POS_W-1:0] acc_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= din;
			for (int i = 1; i < SIDE_N; i++) side_q[i] <= side_q[i-1];
			fm_q[0] <= fm_new;
			ct_q[0] <= '{c: c_l1, t: t_l1};
			for (int i = 1; i < LATE_N; i++) begin
				fm_q[i] <= fm_q[i-1];
				ct_q[i] <= ct_q[i-1];
			end
		end
	end

	ojd_mulq u_mq_a  (.clk, .en, .a(din.g), .b(MQ_W'(j2)), .y(a_l1));
	ojd_mulq u_mq_dz (.clk, .en, .a(din.u[2]), .b(din.u[2]), .y(dz_l1));
	ojd_mulq u_mq_k1 (.clk, .en, .a(a_l1), .b(side_q[MULQ_LAT-1].q), .y(k1_l2));
	ojd_mulq u_mq_k  (.clk, .en, .a(k1_l2), .b(THREE_HALVES), .y(k_l3));

	for (genvar i = 0; i < 3; i++) begin : g_axis
		ojd_mulq u_mq_c  (.clk, .en, .a(din.g), .b(din.u[i]), .y(c_l1[i]));
		ojd_mulq u_mq_t  (.clk, .en, .a(din.tm), .b(din.w[i]), .y(t_l1[i]));
		ojd_mulq u_mq_jj (.clk, .en, .a(k_l3), .b(fm_q[2*MULQ_LAT-1].fm[i]), .y(jj_l4[i]));
		ojd_mulq u_mq_j  (.clk, .en, .a(jj_l4[i]), .b(side_q[4*MULQ_LAT-1].u[i]), .y(j_l5[i]));
	end

	// Oblateness factor 5 z^2/r^2 less one for the equatorial axes and less three for the pole.
	always_comb begin
		d = (dz_l1 << 2) + dz_l1;
		for (int i = 0; i < 3; i++) begin
			fm_new.fneg[i] = (d < ((i == 2) ? THREE_Q32 : ONE_Q32));
			fm_new.fm[i]   = fm_new.fneg[i] ? (((i == 2) ? THREE_Q32 : ONE_Q32) - d)
				: (d - ((i == 2) ? THREE_Q32 : ONE_Q32));
		end
	end

	always_ff @(posedge clk) begin
		logic signed [MQ_W-1:0] sc, sj, st, sum;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sc  = side_q[SIDE_N-1].pneg[i] ? $signed(ct_q[LATE_N-1].c[i])
					: -$signed(ct_q[LATE_N-1].c[i]);
				sj  = (fm_q[LATE_N-1].fneg[i] ^ side_q[SIDE_N-1].pneg[i]) ? -$signed(j_l5[i])
					: $signed(j_l5[i]);
				st  = !side_q[SIDE_N-1].moving ? '0
					: (side_q[SIDE_N-1].vneg[i] ? -$signed(ct_q[LATE_N-1].t[i])
					: $signed(ct_q[LATE_N-1].t[i]));
				sum = sc + sj + st;
				if (sum > ACC_MAX) sum = ACC_MAX;
				if (sum < ACC_MIN) sum = ACC_MIN;
				acc_s11[i] <= side_q[SIDE_N-1].fault ? '0 : sum[POS_W-1:0];
			end
		end
	end

	assign acc = acc_s11;

endmodule

@@ hdl/orbit_j2_thrust_derivatives_top.sv @@
// Orbit derivative engine: point-mass gravity, J2 oblateness and thrust along velocity.
// Input beats arrive on the s_ stream, one spacecraft state per beat; each gives exactly
// one result beat on the m_ stream, in order. Planet and engine constants are written on
// the cfg channel, which always accepts; write it only while no state is in flight.
// Throughput is one state per clock cycle while the receiver keeps m_tready high. An
// accepted input beat passes through the squaring stages, the bit-per-stage square root,
// the bit-per-stage quotient pipelines, the scaled multiplies and summing, and the output
// register before its result appears on m_tvalid.
// Reset clears every valid flag and loads the default Earth constants and engine exhaust
// velocity. When the receiver holds m_tready low the pipeline keeps taking input as long
// as its final stage is empty; once a finished result sits behind the held beat the whole
// pipeline freezes and s_tready drops, so nothing is lost or repeated.
// A zero radius or zero mass raises the fault flag in m_tuser and zeroes the acceleration;
// the position rate and mass rate are still produced.
module orbit_j2_thrust_derivatives_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, mass, thrust_force
	input  logic [ojd_pkg::IN_W-1:0]    s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// rate_x, rate_y, rate_z, accel_x, accel_y, accel_z, mass_rate, zero padding
	output logic [ojd_pkg::OUT_W-1:0]   m_tdata,
	// fault
	output logic                        m_tuser,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [ojd_pkg::CFG_W-1:0]   cfg_data
);
	import ojd_pkg::*;

	logic [MU_W-1:0]   mu_q;
	logic [J2_W-1:0]   j2_q;
	logic [RE_W-1:0]   re_q;
	logic [RESQ_W-1:0] re_sq_q;
	logic [VE_W-1:0]   ve_q;

	logic adv_out, adv;
	logic vld_q [TOTAL_LAT];

	item_t   item;
	front_t  fr, fd;
	mid_t    md;
	acc_in_t ain;
	tail_t   tl, td;

	front_t sq_side_q [SQRT_LAT];
	mid_t   dv_side_q [DIV_LAT];
	tail_t  ac_side_q [ACC_LAT];

	logic [ROOT_W-1:0]    r_root, s_root;
	logic [QUO_W-1:0]     g_quo, q_quo, tm_quo, mr_quo;
	logic                 g_ovf, q_ovf, tm_ovf, mr_ovf;
	logic [2:0][QUO_W-1:0] u_quo, w_quo;
	logic [2:0]           u_ovf, w_ovf;
	logic [RATE_W-1:0]    mr_cap;
	logic [2:0][POS_W-1:0] acc;

	logic              m_tvalid_q;
	logic [OUT_W-1:0]  out_data_q;
	logic              out_fault_q;

	// Configuration registers; the radius is squared once here rather than per state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mu_q <= MU_RESET;
			j2_q <= J2_RESET;
			re_q <= RE_RESET;
			ve_q <= VE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MU:  mu_q <= cfg_data;
				CFG_J2:  j2_q <= cfg_data[J2_W-1:0];
				CFG_RE:  re_q <= cfg_data[RE_W-1:0];
				CFG_VE:  ve_q <= cfg_data[VE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		re_sq_q <= re_q * re_q;
	end

	assign cfg_ready = 1'b1;

	// Stages before the output move as one; an empty last stage lets them close on a held beat.
	assign adv_out  = !m_tvalid_q || m_tready;
	assign adv      = adv_out || !vld_q[TOTAL_LAT-1];
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TOTAL_LAT; i++) vld_q[i] <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= s_tvalid;
			for (int i = 1; i < TOTAL_LAT; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	assign item = item_t'(s_tdata);

	ojd_front u_front (.clk, .en(adv), .item, .res(fr));

	ojd_isqrt u_sqrt_r (.clk, .en(adv), .x(fr.r2), .root(r_root));
	ojd_isqrt u_sqrt_s (.clk, .en(adv), .x(fr.v2), .root(s_root));

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_side_q[0] <= fr;
			for (int i = 1; i < SQRT_LAT; i++) sq_side_q[i] <= sq_side_q[i-1];
		end
	end

	assign fd = sq_side_q[SQRT_LAT-1];

	// Quotients: mu/r^2, (Re/r)^2, thrust over mass, mass flow, and the direction cosines.
	ojd_div u_div_g (.clk, .en(adv), .num({14'd0, mu_q, 64'd0}), .den(fd.r2),
		.quo(g_quo), .ovf(g_ovf));
	ojd_div u_div_q (.clk, .en(adv), .num({10'd0, re_sq_q, 64'd0}), .den(fd.r2),
		.quo(q_quo), .ovf(q_ovf));
	ojd_div u_div_tm (.clk, .en(adv), .num({64'd0, fd.thrust, 32'd0}), .den(DEN_W'(fd.mass)),
		.quo(tm_quo), .ovf(tm_ovf));
	ojd_div u_div_mr (.clk, .en(adv), .num({80'd0, fd.thrust, 16'd0}), .den(DEN_W'(ve_q)),
		.quo(mr_quo), .ovf(mr_ovf));

	for (genvar i = 0; i < 3; i++) begin : g_cos
		ojd_div u_div_u (.clk, .en(adv), .num({48'd0, fd.pm[i], 32'd0}), .den(DEN_W'(r_root)),
			.quo(u_quo[i]), .ovf(u_ovf[i]));
		ojd_div u_div_w (.clk, .en(adv), .num({48'd0, fd.vm[i], 32'd0}), .den(DEN_W'(s_root)),
			.quo(w_quo[i]), .ovf(w_ovf[i]));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_side_q[0] <= '{vel: fd.vel, pneg: fd.pneg, vneg: fd.vneg,
				fault: fd.fault, moving: fd.moving};
			for (int i = 1; i < DIV_LAT; i++) dv_side_q[i] <= dv_side_q[i-1];
		end
	end

	assign md = dv_side_q[DIV_LAT-1];

	always_comb begin
		ain.g      = cap_quo(g_quo, g_ovf);
		ain.q      = cap_quo(q_quo, q_ovf);
		ain.tm     = cap_quo(tm_quo, tm_ovf);
		for (int i = 0; i < 3; i++) begin
			ain.u[i] = cap_quo(u_quo[i], u_ovf[i]);
			ain.w[i] = cap_quo(w_quo[i], w_ovf[i]);
		end
		ain.pneg   = md.pneg;
		ain.vneg   = md.vneg;
		ain.fault  = md.fault;
		ain.moving = md.moving;
		// A zero exhaust velocity shows up as an overflowed quotient and so saturates too.
		mr_cap       = (mr_ovf || (mr_quo > QUO_W'(MR_CAP))) ? MR_CAP : mr_quo[RATE_W-1:0];
		tl.vel       = md.vel;
		tl.mass_rate = RATE_W'(0) - mr_cap;
		tl.fault     = md.fault;
	end

	ojd_accel u_accel (.clk, .en(adv), .j2(j2_q), .din(ain), .acc);

	always_ff @(posedge clk) begin
		if (adv) begin
			ac_side_q[0] <= tl;
			for (int i = 1; i < ACC_LAT; i++) ac_side_q[i] <= ac_side_q[i-1];
		end
	end

	assign td = ac_side_q[ACC_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv_out) begin
			m_tvalid_q <= vld_q[TOTAL_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out) begin
			out_data_q  <= {7'd0, td.mass_rate, acc, td.vel};
			out_fault_q <= td.fault;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_fault_q;

	a_fault_zero_accel: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[287:144] == '0))
		else $error("fault result carries a non-zero acceleration");

	a_mass_rate_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[320:288] == '0) || m_tdata[320]))
		else $error("mass rate is positive");

	a_blocked_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready && vld_q[TOTAL_LAT-1]) |-> !s_tready)
		else $error("input taken while a finished result is blocked");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> vld_q[0])
		else $error("accepted beat did not enter the pipeline");

endmodule
